// ===== hw/rtl/dli_pkg.sv =====
// Shared constants, types and helpers for the diffuse light intensity core.
package dli_pkg;

    localparam int COMP_W    = 32;
    localparam int SMALL_W   = 16;
    localparam int LIMIT     = 30000;
    localparam int BIAS_W    = 10;
    localparam int LEVEL_W   = 8;
    localparam int FULL      = 255;
    localparam int SUM_W     = 32;
    localparam int RAD_W     = SUM_W + 17;
    localparam int LEN_W     = 24;
    localparam int DOT_W     = 33;
    localparam int DEN_W     = 2 * LEN_W;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = 34;
    localparam int RCP_W     = 24;
    localparam int SHIFT_W   = 5;
    localparam int V_W       = 11;
    localparam int SCALE_W   = 11;
    localparam int LVL_NUM_W = 19;

    typedef logic signed [SMALL_W-1:0] small_t;

    typedef struct packed {
        small_t nx;
        small_t ny;
        small_t nz;
        small_t lx;
        small_t ly;
        small_t lz;
    } vec_pair_t;

    // Count of halvings needed for a vector to fit in the limit.
    function automatic logic [SHIFT_W-1:0] shrink_count(
        input logic signed [COMP_W-1:0] a,
        input logic signed [COMP_W-1:0] b,
        input logic signed [COMP_W-1:0] c
    );
        logic [COMP_W:0] ma;
        logic [COMP_W:0] mb;
        logic [COMP_W:0] mc;
        logic [COMP_W:0] mx;
        logic [SHIFT_W-1:0] k;
        ma = a[COMP_W-1] ? -{a[COMP_W-1], a} : {a[COMP_W-1], a};
        mb = b[COMP_W-1] ? -{b[COMP_W-1], b} : {b[COMP_W-1], b};
        mc = c[COMP_W-1] ? -{c[COMP_W-1], c} : {c[COMP_W-1], c};
        mx = (ma > mb) ? ma : mb;
        mx = (mx > mc) ? mx : mc;
        k = '0;
        for (int i = 0; i < 18; i++)
        begin
            if ((mx >> i) > (COMP_W+1)'(LIMIT) &&
                (mx >> (i + 1)) <= (COMP_W+1)'(LIMIT))
            begin
                k = SHIFT_W'(i + 1);
            end
        end
        return k;
    endfunction

    // Halve with truncation toward zero, k times.
    function automatic small_t shrink_comp(
        input logic signed [COMP_W-1:0] a,
        input logic [SHIFT_W-1:0] k
    );
        logic [COMP_W:0] m;
        logic [COMP_W:0] s;
        m = a[COMP_W-1] ? -{a[COMP_W-1], a} : {a[COMP_W-1], a};
        s = m >> k;
        return a[COMP_W-1] ? -s[SMALL_W-1:0] : s[SMALL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/dli_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module dli_sqrt #(
    parameter int IN_W  = dli_pkg::RAD_W,
    parameter int OUT_W = dli_pkg::LEN_W,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  radicand,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [OUT_W-1:0] root,
    output logic [TAG_W-1:0] out_tag
);

    localparam int RW = 2 * OUT_W;

    logic [OUT_W:0]    valid_reg;
    logic [RW-1:0]     rem_reg  [OUT_W+1];
    logic [OUT_W-1:0]  res_reg  [OUT_W+1];
    logic [TAG_W-1:0]  tag_reg  [OUT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[OUT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(radicand);
            res_reg[0] <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic [RW-1:0]    trial_next;
        logic [OUT_W-1:0] cand_next;
        always_comb
        begin
            cand_next  = res_reg[s] | (OUT_W'(1) << B);
            trial_next = RW'(cand_next) * RW'(cand_next);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                res_reg[s+1] <= (trial_next <= rem_reg[s]) ? cand_next : res_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[OUT_W];
    assign root      = res_reg[OUT_W];
    assign out_tag   = tag_reg[OUT_W];

endmodule

// ===== hw/rtl/dli_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dli_div #(
    parameter int NUM_W = dli_pkg::NUM_W,
    parameter int DEN_W = dli_pkg::DEN_W,
    parameter int QUO_W = dli_pkg::QUO_W,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] out_tag
);

    localparam int RW = DEN_W + 1;

    logic [QUO_W:0]    valid_reg;
    logic [RW-1:0]     rem_reg [QUO_W+1];
    logic [NUM_W-1:0]  num_reg [QUO_W+1];
    logic [DEN_W-1:0]  den_reg [QUO_W+1];
    logic [QUO_W-1:0]  q_reg   [QUO_W+1];
    logic [TAG_W-1:0]  tag_reg [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    // Numerator bits above the quotient width seed the initial remainder.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num >> QUO_W);
            num_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic [RW-1:0] sh_next;
        logic [RW-1:0] diff_next;
        always_comb
        begin
            sh_next   = {rem_reg[s][RW-2:0], num_reg[s][B]};
            diff_next = sh_next - RW'(den_reg[s]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                if (sh_next >= RW'(den_reg[s]))
                begin
                    rem_reg[s+1] <= diff_next;
                    q_reg[s+1]   <= q_reg[s] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_reg[s+1] <= sh_next;
                    q_reg[s+1]   <= q_reg[s];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo       = q_reg[QUO_W];
    assign out_tag   = tag_reg[QUO_W];

endmodule

// ===== hw/rtl/dli_front.sv =====
// Front stages: vector shrink, squares, sums and dot product.
module dli_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [6*dli_pkg::COMP_W-1:0]      in_data,
    output logic                              out_valid,
    output logic [dli_pkg::SUM_W-1:0]         sum_n,
    output logic [dli_pkg::SUM_W-1:0]         sum_l,
    output logic signed [dli_pkg::DOT_W-1:0]  dot
);

    localparam int CW = dli_pkg::COMP_W;
    localparam int PW = 2 * dli_pkg::SMALL_W;

    logic [3:0]                     valid_reg;
    logic [dli_pkg::SHIFT_W-1:0]    kn_reg;
    logic [dli_pkg::SHIFT_W-1:0]    kl_reg;
    logic [6*CW-1:0]                raw_reg;
    dli_pkg::vec_pair_t             vec_reg;
    logic signed [PW-1:0]           prod_reg [9];
    logic [dli_pkg::SUM_W-1:0]      sum_n_reg;
    logic [dli_pkg::SUM_W-1:0]      sum_l_reg;
    logic signed [dli_pkg::DOT_W-1:0] dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg <= in_data;
            kn_reg  <= dli_pkg::shrink_count(in_data[CW-1:0], in_data[2*CW-1:CW],
                                             in_data[3*CW-1:2*CW]);
            kl_reg  <= dli_pkg::shrink_count(in_data[4*CW-1:3*CW], in_data[5*CW-1:4*CW],
                                             in_data[6*CW-1:5*CW]);
            vec_reg.nx <= dli_pkg::shrink_comp(raw_reg[CW-1:0], kn_reg);
            vec_reg.ny <= dli_pkg::shrink_comp(raw_reg[2*CW-1:CW], kn_reg);
            vec_reg.nz <= dli_pkg::shrink_comp(raw_reg[3*CW-1:2*CW], kn_reg);
            vec_reg.lx <= dli_pkg::shrink_comp(raw_reg[4*CW-1:3*CW], kl_reg);
            vec_reg.ly <= dli_pkg::shrink_comp(raw_reg[5*CW-1:4*CW], kl_reg);
            vec_reg.lz <= dli_pkg::shrink_comp(raw_reg[6*CW-1:5*CW], kl_reg);
            prod_reg[0] <= PW'(vec_reg.nx) * PW'(vec_reg.nx);
            prod_reg[1] <= PW'(vec_reg.ny) * PW'(vec_reg.ny);
            prod_reg[2] <= PW'(vec_reg.nz) * PW'(vec_reg.nz);
            prod_reg[3] <= PW'(vec_reg.lx) * PW'(vec_reg.lx);
            prod_reg[4] <= PW'(vec_reg.ly) * PW'(vec_reg.ly);
            prod_reg[5] <= PW'(vec_reg.lz) * PW'(vec_reg.lz);
            prod_reg[6] <= PW'(vec_reg.nx) * PW'(vec_reg.lx);
            prod_reg[7] <= PW'(vec_reg.ny) * PW'(vec_reg.ly);
            prod_reg[8] <= PW'(vec_reg.nz) * PW'(vec_reg.lz);
            sum_n_reg <= dli_pkg::SUM_W'(prod_reg[0]) + dli_pkg::SUM_W'(prod_reg[1])
                       + dli_pkg::SUM_W'(prod_reg[2]);
            sum_l_reg <= dli_pkg::SUM_W'(prod_reg[3]) + dli_pkg::SUM_W'(prod_reg[4])
                       + dli_pkg::SUM_W'(prod_reg[5]);
            dot_reg   <= dli_pkg::DOT_W'(prod_reg[6]) + dli_pkg::DOT_W'(prod_reg[7])
                       + dli_pkg::DOT_W'(prod_reg[8]);
        end
    end

    assign out_valid = valid_reg[3];
    assign sum_n     = sum_n_reg;
    assign sum_l     = sum_l_reg;
    assign dot       = dot_reg;

endmodule

// ===== hw/rtl/diffuse_light_intensity_core.sv =====
// Top level of the diffuse light intensity core.
// The path from input transfer to output valid runs through the front, roots,
// lengths, divider, level, scale divider and output register stages.
// Throughput: one item per cycle; every stage holds while a result waits unaccepted.
// Reset: asynchronous active low; clears valid bits and bias_reg to 0.
module diffuse_light_intensity_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // normal_x, normal_y, normal_z, light_x, light_y, light_z
    input  logic [6*dli_pkg::COMP_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // brightness
    output logic [dli_pkg::LEVEL_W-1:0]   m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dli_pkg::BIAS_W-1:0]    cfg_data
);

    localparam int LW  = dli_pkg::LEN_W;
    localparam int DW  = dli_pkg::DOT_W;
    localparam int QW  = dli_pkg::QUO_W;
    localparam int VW  = QW + 9;
    localparam int SW  = dli_pkg::SCALE_W;
    localparam int PW  = dli_pkg::LVL_NUM_W;

    logic                        en;
    logic [dli_pkg::BIAS_W-1:0]  bias_reg;
    logic                        out_valid_reg;
    logic [dli_pkg::LEVEL_W-1:0] out_data_reg;

    logic                        f_valid;
    logic [dli_pkg::SUM_W-1:0]   sum_n;
    logic [dli_pkg::SUM_W-1:0]   sum_l;
    logic signed [DW-1:0]        dot;

    logic                        r_valid;
    logic [LW-1:0]               root_n;
    logic [LW-1:0]               root_l;
    logic [DW-1:0]               dot_r;
    logic                        rl_unused;
    logic [DW-1:0]               dot_l_unused;

    logic                        m_valid_reg;
    logic [LW-1:0]               len_n_reg;
    logic [LW-1:0]               len_l_reg;
    logic [DW-1:0]               dot_m_reg;
    logic                        p_valid_reg;
    logic [dli_pkg::DEN_W-1:0]   den_reg;
    logic [DW-1:0]               dot_p_reg;

    logic                        d_valid;
    logic [QW-1:0]               qmag;
    logic                        neg_q;

    logic                        b_valid_reg;
    logic [dli_pkg::V_W-1:0]     v_reg;
    logic [VW-1:0]               v_next;
    logic [DW-1:0]               dmag;
    logic [SW-1:0]               scale_den;
    logic [PW-1:0]               scale_num;
    logic                        sat_next;

    logic                        s_valid;
    logic [dli_pkg::LEVEL_W-1:0] level_q;
    logic                        level_sat;

    assign en            = !(out_valid_reg && !m_axis_tready);
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (cfg_valid)
        begin
            bias_reg <= cfg_data;
        end
    end

    dli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .sum_n     (sum_n),
        .sum_l     (sum_l),
        .dot       (dot)
    );

    dli_sqrt #(.TAG_W(DW)) u_sqrt_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  ({1'b0, sum_n, 16'd0}),
        .in_tag    (dot),
        .out_valid (r_valid),
        .root      (root_n),
        .out_tag   (dot_r)
    );

    dli_sqrt #(.TAG_W(DW)) u_sqrt_l (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  ({1'b0, sum_l, 16'd0}),
        .in_tag    (dot),
        .out_valid (rl_unused),
        .root      (root_l),
        .out_tag   (dot_l_unused)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= r_valid & rl_unused;
            p_valid_reg   <= m_valid_reg;
            b_valid_reg   <= d_valid;
            out_valid_reg <= s_valid;
        end
    end

    assign dmag = dot_p_reg[DW-1] ? -dot_p_reg : dot_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_n_reg <= (root_n < LW'(256)) ? LW'(256) : root_n;
            len_l_reg <= (root_l < LW'(256)) ? LW'(256) : root_l;
            dot_m_reg <= dot_r ^ (dot_l_unused & '0);
            den_reg   <= dli_pkg::DEN_W'(len_n_reg) * dli_pkg::DEN_W'(len_l_reg);
            dot_p_reg <= dot_m_reg;
        end
    end

    dli_div #(.TAG_W(1)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .num       ({dmag[DW-2:0], 32'd0}),
        .den       (den_reg),
        .in_tag    (dot_p_reg[DW-1]),
        .out_valid (d_valid),
        .quo       (qmag),
        .out_tag   (neg_q)
    );

    // Cosine of either sign: trunc((+-q*256 + b*65536)/65536), floored at 0.
    always_comb
    begin
        logic [VW-1:0] pos;
        logic [VW-1:0] bb;
        logic [VW-1:0] qq;
        pos = VW'({qmag, 8'd0}) + VW'({bias_reg, 16'd0});
        bb  = VW'({bias_reg, 16'd0});
        qq  = VW'({qmag, 8'd0});
        if (!neg_q)
        begin
            v_next = pos >> 16;
        end
        else if (qq >= bb)
        begin
            v_next = '0;
        end
        else
        begin
            v_next = (bb - qq) >> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next[dli_pkg::V_W-1:0];
        end
    end

    // Flag a level of 256 or more; the quotient is dropped for those.
    assign scale_den = SW'(dli_pkg::FULL) + SW'(bias_reg);
    assign scale_num = PW'(v_reg) * PW'(dli_pkg::FULL);
    assign sat_next  = scale_num >= {scale_den, 8'd0};

    dli_div #(
        .NUM_W (PW),
        .DEN_W (SW),
        .QUO_W (dli_pkg::LEVEL_W),
        .TAG_W (1)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .num       (scale_num),
        .den       (scale_den),
        .in_tag    (sat_next),
        .out_valid (s_valid),
        .quo       (level_q),
        .out_tag   (level_sat)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= level_sat ? dli_pkg::LEVEL_W'(dli_pkg::FULL) : level_q;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
